// ----- hw/rtl/lanczos_image_decimator_top_assert.svh -----
// Assertion macros used by the port-level checker of the Lanczos image decimator.
`ifndef LANCZOS_IMAGE_DECIMATOR_TOP_ASSERT_SVH
`define LANCZOS_IMAGE_DECIMATOR_TOP_ASSERT_SVH
// Consequence holds in the same cycle as the antecedent.
`define LID_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Consequence holds in the cycle after the antecedent.
`define LID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- hw/rtl/lid_pkg.sv -----
// Package of the Lanczos image decimator: constants, codes, states and control structs.
`default_nettype none
package lid_pkg;
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_MAX_HALF   = 32;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_KHALF      = 3'd5;

	localparam logic [8:0]  RST_IN_WIDTH   = 9'd256;
	localparam logic [8:0]  RST_IN_HEIGHT  = 9'd256;
	localparam logic [8:0]  RST_OUT_WIDTH  = 9'd128;
	localparam logic [8:0]  RST_OUT_HEIGHT = 9'd128;
	localparam logic [15:0] RST_SCALE      = 16'd8192;
	localparam logic [5:0]  RST_KHALF      = 6'd8;

	localparam logic [1:0] OP_PIX  = 2'd0;
	localparam logic [1:0] OP_COEF = 2'd1;
	localparam logic [1:0] OP_CMP  = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_WRITE = 2'd1;
	localparam logic [1:0] ST_ERR   = 2'd2;

	// Tap positions are (2n+1)*scale + 4096*k; the source index is that value >> 13.
	localparam int TAP_W   = 28;
	localparam int TAP_SH  = 13;
	localparam int HALF_SH = 12;

	localparam int HS_W  = 32;
	localparam int W_W   = 24;
	localparam int VS_W  = 44;
	localparam int NUM_W = 48;
	localparam int DEN_W = 33;
	localparam int Q_W   = NUM_W + 1;
	localparam int RV_W  = 17;

	// Row value: round(hs*256/hw) = floor((512*hs + hw) / (2*hw)).
	localparam int ROW_NUM_SH = 9;
	// Output: floor((2*vs + 256*vw) / (512*vw)).
	localparam int FIN_W_SH = 8;
	localparam int FIN_D_SH = 9;

	localparam int RV_MAX  = 65535;
	localparam int RV_MIN  = -65536;
	localparam int PIX_MAX = 255;

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_HW, S_HW_END, S_HW_CHK, S_ROW, S_TAP, S_TAP_END,
		S_RDIV, S_RWAIT, S_RCOEF, S_RACC, S_FCHK, S_FWAIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic init;
		logic hw_step;
		logic row_setup;
		logic row_next;
		logic tap_step;
		logic div_row;
		logic rv_load;
		logic coef_rd;
		logic v_acc;
		logic div_fin;
		logic res_ok;
		logic res_err;
	} ctrl_t;

	typedef struct packed {
		logic cmp_ok;
		logic kc_last;
		logic kv_last;
		logic row_in;
		logic hw_pos;
		logic vw_pos;
		logic div_done;
	} stat_t;
endpackage
`default_nettype wire

// ----- hw/rtl/lid_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module lid_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- hw/rtl/lid_div.sv -----
// Restoring signed floor divider, one quotient bit per cycle.
`default_nettype none
module lid_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [lid_pkg::NUM_W-1:0] num,
	input  logic [lid_pkg::DEN_W-1:0]        den,
	output logic                             done,
	output logic signed [lid_pkg::Q_W-1:0]   quot
);
	localparam int NUM_W = lid_pkg::NUM_W;
	localparam int DEN_W = lid_pkg::DEN_W;
	localparam int Q_W   = lid_pkg::Q_W;
	localparam int CNT_W = $clog2(NUM_W);

	logic                    run_q, fix_q, done_q, neg_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [NUM_W-1:0]        mq_q;
	logic [DEN_W-1:0]        rem_q, den_q;
	logic signed [Q_W-1:0]   quot_q;
	logic [DEN_W:0]          rem_sh, rem_sub;
	logic                    ge;

	assign rem_sh  = {rem_q, mq_q[NUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign ge      = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fix_q;
			fix_q  <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					run_q <= 1'b0;
					fix_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1];
			mq_q  <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			mq_q  <= {mq_q[NUM_W-2:0], ge};
		end
		// A negative dividend with a remainder rounds one further down.
		if (fix_q) begin
			quot_q <= neg_q ? -(Q_W'(mq_q) + Q_W'(rem_q != '0)) : Q_W'(mq_q);
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule
`default_nettype wire

// ----- hw/rtl/lid_ctrl.sv -----
// Controller state machine of the Lanczos image decimator.
`default_nettype none
module lid_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  lid_pkg::stat_t  stat,
	output lid_pkg::ctrl_t  cmd
);
	lid_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lid_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			lid_pkg::S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					if (stat.cmp_ok) begin
						state_d = lid_pkg::S_INIT;
					end
				end
			end
			lid_pkg::S_INIT: begin
				cmd.init = 1'b1;
				state_d  = lid_pkg::S_HW;
			end
			lid_pkg::S_HW: begin
				cmd.hw_step = 1'b1;
				if (stat.kc_last) begin
					state_d = lid_pkg::S_HW_END;
				end
			end
			lid_pkg::S_HW_END: state_d = lid_pkg::S_HW_CHK;
			lid_pkg::S_HW_CHK: begin
				if (!stat.hw_pos) begin
					cmd.res_err = 1'b1;
					state_d     = lid_pkg::S_IDLE;
				end else begin
					state_d = lid_pkg::S_ROW;
				end
			end
			lid_pkg::S_ROW: begin
				if (stat.row_in) begin
					cmd.row_setup = 1'b1;
					state_d       = lid_pkg::S_TAP;
				end else begin
					cmd.row_next = 1'b1;
					if (stat.kv_last) begin
						state_d = lid_pkg::S_FCHK;
					end
				end
			end
			lid_pkg::S_TAP: begin
				cmd.tap_step = 1'b1;
				if (stat.kc_last) begin
					state_d = lid_pkg::S_TAP_END;
				end
			end
			lid_pkg::S_TAP_END: state_d = lid_pkg::S_RDIV;
			lid_pkg::S_RDIV: begin
				cmd.div_row = 1'b1;
				state_d     = lid_pkg::S_RWAIT;
			end
			lid_pkg::S_RWAIT: begin
				if (stat.div_done) begin
					cmd.rv_load = 1'b1;
					state_d     = lid_pkg::S_RCOEF;
				end
			end
			lid_pkg::S_RCOEF: begin
				cmd.coef_rd = 1'b1;
				state_d     = lid_pkg::S_RACC;
			end
			lid_pkg::S_RACC: begin
				cmd.v_acc    = 1'b1;
				cmd.row_next = 1'b1;
				state_d      = stat.kv_last ? lid_pkg::S_FCHK : lid_pkg::S_ROW;
			end
			lid_pkg::S_FCHK: begin
				if (!stat.vw_pos) begin
					cmd.res_err = 1'b1;
					state_d     = lid_pkg::S_IDLE;
				end else begin
					cmd.div_fin = 1'b1;
					state_d     = lid_pkg::S_FWAIT;
				end
			end
			lid_pkg::S_FWAIT: begin
				if (stat.div_done) begin
					cmd.res_ok = 1'b1;
					state_d    = lid_pkg::S_IDLE;
				end
			end
			default: state_d = lid_pkg::S_IDLE;
		endcase
	end

	assign busy = (state_q != lid_pkg::S_IDLE);
endmodule
`default_nettype wire

// ----- hw/rtl/lid_datapath.sv -----
// Datapath of the Lanczos image decimator: registers, stores, accumulators, divider.
`default_nettype none
module lid_datapath #(
	parameter int MAX_WIDTH  = lid_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = lid_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_HALF   = lid_pkg::DEF_MAX_HALF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lid_pkg::ctrl_t                      cmd,
	output lid_pkg::stat_t                      stat,
	input  logic [1:0]                          opcode,
	input  logic [7:0]                          row_index,
	input  logic [7:0]                          col_index,
	input  logic [7:0]                          pixel_value,
	input  logic signed [15:0]                  coefficient,
	input  logic                                cfg_wr_en,
	input  logic [lid_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lid_pkg::CFG_W-1:0]           cfg_data,
	output logic                                done,
	output logic [7:0]                          out_pixel,
	output logic [1:0]                          status
);
	localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int KA_W   = $clog2(MAX_HALF + 1);
	localparam int KW     = KA_W + 1;
	localparam int TAP_W  = lid_pkg::TAP_W;
	localparam int XW     = lid_pkg::TAP_W - lid_pkg::TAP_SH;
	localparam int HS_W   = lid_pkg::HS_W;
	localparam int W_W    = lid_pkg::W_W;
	localparam int VS_W   = lid_pkg::VS_W;
	localparam int NUM_W  = lid_pkg::NUM_W;
	localparam int DEN_W  = lid_pkg::DEN_W;
	localparam int Q_W    = lid_pkg::Q_W;
	localparam int RV_W   = lid_pkg::RV_W;

	logic [8:0]  in_width_q, in_height_q, out_width_q, out_height_q;
	logic [15:0] scale_q;
	logic [5:0]  khalf_q;

	logic [XW-1:0]            eff_w, eff_h, x_col, y_row;
	logic signed [KW-1:0]     kmax, kmax_q, kc_q, kv_q, kc_abs, kv_abs;
	logic signed [TAP_W-1:0]  bcol_q, brow_q, tcol_q, trow_q, koff, tstep;
	logic [ADDR_W-1:0]        row_base_q, img_waddr, img_raddr;
	logic [KA_W-1:0]          k_raddr;
	logic [7:0]               pdata;
	logic [15:0]              kdata_u;
	logic signed [15:0]       kdata;
	logic signed [24:0]       tprod;
	logic signed [32:0]       vprod;
	logic signed [HS_W-1:0]   hs_q;
	logic signed [W_W-1:0]    hw_q, vw_q;
	logic signed [VS_W-1:0]   vs_q;
	logic signed [RV_W-1:0]   rv_q, rv_sat;
	logic signed [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]         div_den;
	logic signed [Q_W-1:0]    quot;
	logic                     div_done, col_in, row_in;
	logic                     pix_in, coef_in, cmp_ok, img_we, k_we;
	logic                     hacc_s1, tacc_s1, done_q;
	logic [1:0]               imm_status, status_q;
	logic [7:0]               pix_q, pix_sat;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q   <= lid_pkg::RST_IN_WIDTH;
			in_height_q  <= lid_pkg::RST_IN_HEIGHT;
			out_width_q  <= lid_pkg::RST_OUT_WIDTH;
			out_height_q <= lid_pkg::RST_OUT_HEIGHT;
			scale_q      <= lid_pkg::RST_SCALE;
			khalf_q      <= lid_pkg::RST_KHALF;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				lid_pkg::CFG_IN_WIDTH:   in_width_q   <= cfg_data[8:0];
				lid_pkg::CFG_IN_HEIGHT:  in_height_q  <= cfg_data[8:0];
				lid_pkg::CFG_OUT_WIDTH:  out_width_q  <= cfg_data[8:0];
				lid_pkg::CFG_OUT_HEIGHT: out_height_q <= cfg_data[8:0];
				lid_pkg::CFG_SCALE:      scale_q      <= cfg_data;
				lid_pkg::CFG_KHALF:      khalf_q      <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign eff_w = (XW'(in_width_q) < XW'(MAX_WIDTH)) ? XW'(in_width_q) : XW'(MAX_WIDTH);
	assign eff_h = (XW'(in_height_q) < XW'(MAX_HEIGHT)) ? XW'(in_height_q) : XW'(MAX_HEIGHT);
	assign kmax  = (int'(khalf_q) > MAX_HALF) ? KW'(MAX_HALF) : KW'(khalf_q);

	// Decode of the item on the input ports.
	assign pix_in  = (XW'(row_index) < eff_h) && (XW'(col_index) < eff_w);
	assign coef_in = (int'(col_index) <= MAX_HALF);
	assign cmp_ok  = (opcode == lid_pkg::OP_CMP) && ({1'b0, row_index} < out_height_q)
	                 && ({1'b0, col_index} < out_width_q);

	always_comb begin
		case (opcode)
			lid_pkg::OP_PIX:  imm_status = pix_in ? lid_pkg::ST_WRITE : lid_pkg::ST_ERR;
			lid_pkg::OP_COEF: imm_status = coef_in ? lid_pkg::ST_WRITE : lid_pkg::ST_ERR;
			default:          imm_status = lid_pkg::ST_ERR;
		endcase
	end

	assign img_we    = cmd.accept && (opcode == lid_pkg::OP_PIX) && pix_in;
	assign k_we      = cmd.accept && (opcode == lid_pkg::OP_COEF) && coef_in;
	assign img_waddr = ADDR_W'(ADDR_W'(row_index) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(col_index);

	// Tap geometry.
	assign koff   = TAP_W'(kmax_q) <<< lid_pkg::HALF_SH;
	assign tstep  = TAP_W'(1) <<< lid_pkg::HALF_SH;
	assign x_col  = tcol_q[TAP_W-1:lid_pkg::TAP_SH];
	assign y_row  = trow_q[TAP_W-1:lid_pkg::TAP_SH];
	assign col_in = !tcol_q[TAP_W-1] && (x_col < eff_w);
	assign row_in = !trow_q[TAP_W-1] && (y_row < eff_h);
	assign kc_abs = kc_q[KW-1] ? -kc_q : kc_q;
	assign kv_abs = kv_q[KW-1] ? -kv_q : kv_q;
	assign k_raddr   = cmd.coef_rd ? kv_abs[KA_W-1:0] : kc_abs[KA_W-1:0];
	assign img_raddr = row_base_q + ADDR_W'(x_col);

	lid_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH * MAX_HEIGHT)) u_img (
		.clk   (clk),
		.we    (img_we),
		.waddr (img_waddr),
		.wdata (pixel_value),
		.raddr (img_raddr),
		.rdata (pdata)
	);

	lid_ram #(.WIDTH(16), .DEPTH(MAX_HALF + 1)) u_kern (
		.clk   (clk),
		.we    (k_we),
		.waddr (KA_W'(col_index)),
		.wdata (coefficient),
		.raddr (k_raddr),
		.rdata (kdata_u)
	);

	assign kdata = $signed(kdata_u);
	assign tprod = kdata * $signed({1'b0, pdata});
	assign vprod = kdata * rv_q;

	// Division operands: row renormalization or final vertical renormalization.
	always_comb begin
		if (cmd.div_fin) begin
			div_num = (NUM_W'(vs_q) <<< 1) + (NUM_W'(vw_q) <<< lid_pkg::FIN_W_SH);
			div_den = DEN_W'(vw_q) << lid_pkg::FIN_D_SH;
		end else begin
			div_num = (NUM_W'(hs_q) <<< lid_pkg::ROW_NUM_SH) + NUM_W'(hw_q);
			div_den = DEN_W'(hw_q) << 1;
		end
	end

	lid_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_row | cmd.div_fin),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (quot)
	);

	always_comb begin
		if (quot > lid_pkg::RV_MAX) begin
			rv_sat = RV_W'(lid_pkg::RV_MAX);
		end else if (quot < lid_pkg::RV_MIN) begin
			rv_sat = RV_W'(lid_pkg::RV_MIN);
		end else begin
			rv_sat = quot[RV_W-1:0];
		end
		if (quot < 0) begin
			pix_sat = '0;
		end else if (quot > lid_pkg::PIX_MAX) begin
			pix_sat = 8'(lid_pkg::PIX_MAX);
		end else begin
			pix_sat = quot[7:0];
		end
	end

	// Read-data valid flags, set in the cycle after their address, and the done strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hacc_s1 <= 1'b0;
			tacc_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			hacc_s1 <= cmd.hw_step && col_in;
			tacc_s1 <= cmd.tap_step && col_in;
			done_q  <= (cmd.accept && !cmp_ok) || cmd.res_ok || cmd.res_err;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			bcol_q <= $signed(TAP_W'(TAP_W'({col_index, 1'b1}) * TAP_W'(scale_q)));
			brow_q <= $signed(TAP_W'(TAP_W'({row_index, 1'b1}) * TAP_W'(scale_q)));
			kmax_q <= kmax;
		end
		if (cmd.init) begin
			kc_q   <= -kmax_q;
			tcol_q <= bcol_q - koff;
			kv_q   <= -kmax_q;
			trow_q <= brow_q - koff;
			hw_q   <= '0;
			vs_q   <= '0;
			vw_q   <= '0;
		end
		if (cmd.hw_step || cmd.tap_step) begin
			kc_q   <= kc_q + KW'(1);
			tcol_q <= tcol_q + tstep;
		end
		if (cmd.row_setup) begin
			kc_q       <= -kmax_q;
			tcol_q     <= bcol_q - koff;
			hs_q       <= '0;
			row_base_q <= ADDR_W'(ADDR_W'(y_row) * ADDR_W'(MAX_WIDTH));
		end
		if (cmd.row_next) begin
			kv_q   <= kv_q + KW'(1);
			trow_q <= trow_q + tstep;
		end
		if (hacc_s1) begin
			hw_q <= hw_q + W_W'(kdata);
		end
		if (tacc_s1) begin
			hs_q <= hs_q + HS_W'(tprod);
		end
		if (cmd.rv_load) begin
			rv_q <= rv_sat;
		end
		if (cmd.v_acc) begin
			vs_q <= vs_q + VS_W'(vprod);
			vw_q <= vw_q + W_W'(kdata);
		end
		if (cmd.accept && !cmp_ok) begin
			status_q <= imm_status;
			pix_q    <= '0;
		end else if (cmd.res_err) begin
			status_q <= lid_pkg::ST_ERR;
			pix_q    <= '0;
		end else if (cmd.res_ok) begin
			status_q <= lid_pkg::ST_OK;
			pix_q    <= pix_sat;
		end
	end

	assign stat.cmp_ok   = cmp_ok;
	assign stat.kc_last  = (kc_q == kmax_q);
	assign stat.kv_last  = (kv_q == kmax_q);
	assign stat.row_in   = row_in;
	assign stat.hw_pos   = !hw_q[W_W-1] && (hw_q != '0);
	assign stat.vw_pos   = !vw_q[W_W-1] && (vw_q != '0);
	assign stat.div_done = div_done;

	assign done      = done_q;
	assign out_pixel = pix_q;
	assign status    = status_q;
endmodule
`default_nettype wire

// ----- hw/rtl/lanczos_image_decimator_top.sv -----
// Top level of the Lanczos image decimator: controller and datapath.
// A write or a rejected item gives its result in the cycle after the transfer.
// A computed pixel runs a weight pass over 2K+1 taps, a filter pass and a row division
// per source row in range, and a final division (K = kernel_half, at most MAX_HALF).
// The divider takes 48 serial steps; the filter loop takes one tap per cycle.
// Reset clears control state and loads the register defaults; the stores are undefined.
`default_nettype none
module lanczos_image_decimator_top #(
	parameter int MAX_WIDTH  = lid_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = lid_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_HALF   = lid_pkg::DEF_MAX_HALF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Command channel: a transfer happens when start is high while busy is low.
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     opcode,
	input  logic [7:0]                     row_index,
	input  logic [7:0]                     col_index,
	input  logic [7:0]                     pixel_value,
	input  logic signed [15:0]             coefficient,
	// Register write port; indexes beyond the register list are ignored.
	input  logic                           cfg_wr_en,
	input  logic [lid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lid_pkg::CFG_W-1:0]      cfg_data,
	// Result channel: done marks a one-cycle transfer that cannot be held off.
	output logic                           done,
	output logic [7:0]                     out_pixel,
	output logic [1:0]                     status
);
	lid_pkg::ctrl_t cmd;
	lid_pkg::stat_t stat;

	// The controller sequences the weight pass, one filtered row at a time, the row
	// divisions and the final vertical division.
	lid_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	// The datapath holds the image and kernel stores, tap counters, accumulators
	// and the divider, and registers the result.
	lid_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_HALF   (MAX_HALF)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.opcode      (opcode),
		.row_index   (row_index),
		.col_index   (col_index),
		.pixel_value (pixel_value),
		.coefficient (coefficient),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.out_pixel   (out_pixel),
		.status      (status)
	);
endmodule
`default_nettype wire

// ----- hw/rtl/lid_checker.sv -----
// Port-level checker of the Lanczos image decimator and its bind to the top level.
`default_nettype none
`include "lanczos_image_decimator_top_assert.svh"
module lid_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] opcode,
	input logic       done,
	input logic [7:0] out_pixel,
	input logic [1:0] status
);
	`LID_ASSERT_NEXT(a_write_result, start && !busy && opcode == lid_pkg::OP_PIX, done && status != lid_pkg::ST_OK, "pixel write gave no write or error result")
	`LID_ASSERT_NEXT(a_compute_starts, start && !busy && opcode == lid_pkg::OP_CMP, busy || (done && status == lid_pkg::ST_ERR), "compute neither started nor rejected")
	`LID_ASSERT_NOW(a_zero_pixel, done && status != lid_pkg::ST_OK, out_pixel == 8'd0, "non-pixel result carries a pixel")
	`LID_ASSERT_NOW(a_ok_after_busy, done && status == lid_pkg::ST_OK, $past(busy), "computed pixel without prior work")
endmodule

bind lanczos_image_decimator_top lid_checker u_lid_checker (.*);
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the Lanczos image decimator: directed table, random phases, predictor.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import lid_pkg::*;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] opcode;
	logic [7:0] row_index;
	logic [7:0] col_index;
	logic [7:0] pixel_value;
	logic signed [15:0] coefficient;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic done;
	logic [7:0] out_pixel;
	logic [1:0] status;

	lanczos_image_decimator_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .row_index(row_index), .col_index(col_index),
		.pixel_value(pixel_value), .coefficient(coefficient),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .out_pixel(out_pixel), .status(status)
	);

	// One expected result of the block.
	typedef struct {
		logic [7:0] pix;
		logic [1:0] st;
	} pixel_result_t;

	// One row of the directed table; when known is set the expected result is typed in.
	typedef struct {
		logic [1:0] op;
		logic [7:0] row;
		logic [7:0] col;
		logic [7:0] pv;
		logic [15:0] cf;
		bit known;
		logic [7:0] pix;
		logic [1:0] st;
	} directed_row_t;

	pixel_result_t pending_pixels[$];
	int mismatches;
	int results_seen;
	int pixels_computed;
	int errors_seen;

	// Predictor copy of the block's registers and stores.
	int unsigned src_w, src_h, dst_w, dst_h, scale_q12, taps_half;
	logic [7:0] plane[0:65535];
	int kernel_taps[0:DEF_MAX_HALF];

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint floor_quot(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	// Source index sampled by tap k around output position n; -1 when negative.
	function automatic longint source_index(int unsigned n, int k);
		longint t;
		t = longint'(2 * n + 1) * longint'(scale_q12) + 64'sd4096 * k;
		if (t < 0)
			return -1;
		return t >>> 13;
	endfunction

	function automatic int tap_coef(int k);
		return kernel_taps[k < 0 ? -k : k];
	endfunction

	// Filters one output pixel: horizontal pass per source row, then vertical.
	function automatic logic [1:0] filter_pixel(int unsigned orow, int unsigned ocol,
		output logic [7:0] pix);
		int kh;
		int k;
		int kv;
		longint w;
		longint h;
		longint hw;
		longint vw;
		longint vs;
		longint hs;
		longint rv;
		longint x;
		longint y;
		longint v;
		kh = (taps_half < DEF_MAX_HALF) ? taps_half : DEF_MAX_HALF;
		w = (src_w < DEF_MAX_WIDTH) ? src_w : DEF_MAX_WIDTH;
		h = (src_h < DEF_MAX_HEIGHT) ? src_h : DEF_MAX_HEIGHT;
		hw = 0;
		vw = 0;
		vs = 0;
		pix = 8'd0;
		for (k = -kh; k <= kh; k++) begin
			x = source_index(ocol, k);
			if (x >= 0 && x < w)
				hw += tap_coef(k);
		end
		if (hw <= 0)
			return ST_ERR;
		for (kv = -kh; kv <= kh; kv++) begin
			y = source_index(orow, kv);
			if (y >= 0 && y < h) begin
				hs = 0;
				for (k = -kh; k <= kh; k++) begin
					x = source_index(ocol, k);
					if (x >= 0 && x < w)
						hs += longint'(tap_coef(k)) * plane[y * DEF_MAX_WIDTH + x];
				end
				rv = floor_quot(2 * hs * 256 + hw, 2 * hw);
				if (rv > RV_MAX)
					rv = RV_MAX;
				if (rv < RV_MIN)
					rv = RV_MIN;
				vs += longint'(tap_coef(kv)) * rv;
				vw += tap_coef(kv);
			end
		end
		if (vw <= 0)
			return ST_ERR;
		v = floor_quot(2 * vs + 256 * vw, 512 * vw);
		if (v < 0)
			v = 0;
		if (v > PIX_MAX)
			v = PIX_MAX;
		pix = v[7:0];
		return ST_OK;
	endfunction

	// Applies one command to the predictor state and returns its result.
	function automatic pixel_result_t apply_command(logic [1:0] op, logic [7:0] row,
		logic [7:0] col, logic [7:0] pv, logic [15:0] cf);
		pixel_result_t r;
		int unsigned ew;
		int unsigned eh;
		r.pix = 8'd0;
		r.st = ST_ERR;
		ew = (src_w < DEF_MAX_WIDTH) ? src_w : DEF_MAX_WIDTH;
		eh = (src_h < DEF_MAX_HEIGHT) ? src_h : DEF_MAX_HEIGHT;
		case (op)
			OP_PIX: begin
				if (row < eh && col < ew) begin
					plane[row * DEF_MAX_WIDTH + col] = pv;
					r.st = ST_WRITE;
				end
			end
			OP_COEF: begin
				if (col <= DEF_MAX_HALF) begin
					kernel_taps[col] = $signed(cf);
					r.st = ST_WRITE;
				end
			end
			OP_CMP: begin
				if (row < dst_h && col < dst_w)
					r.st = filter_pixel(row, col, r.pix);
				if (r.st != ST_OK)
					r.pix = 8'd0;
			end
			default: ;
		endcase
		return r;
	endfunction

	// Checks every result against the oldest pending expectation.
	always @(posedge clk) begin
		pixel_result_t e;
		if (arst_n && done) begin
			results_seen++;
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result pixel=%0d status=%0d", out_pixel, status);
			end else begin
				e = pending_pixels.pop_front();
				if (status == ST_OK)
					pixels_computed++;
				if (status == ST_ERR)
					errors_seen++;
				if (out_pixel !== e.pix || status !== e.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: expected pixel=%0d status=%0d, got pixel=%0d status=%0d",
							e.pix, e.st, out_pixel, status);
				end
			end
		end
	end

	// Idle time between transfers: mostly none or short, now and then long.
	function automatic int pick_gap();
		if ($urandom_range(9) < 6)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(60, 20);
		return $urandom_range(3, 1);
	endfunction

	// Presents one command and holds it until the block takes it.
	task automatic send_command(logic [1:0] op, logic [7:0] row, logic [7:0] col,
		logic [7:0] pv, logic [15:0] cf, bit known, pixel_result_t typed);
		pixel_result_t r;
		int gap;
		r = apply_command(op, row, col, pv, cf);
		pending_pixels.push_back(known ? typed : r);
		start <= 1'b1;
		opcode <= op;
		row_index <= row;
		col_index <= col;
		pixel_value <= pv;
		coefficient <= cf;
		do
			@(posedge clk);
		while (busy);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_predicted(logic [1:0] op, logic [7:0] row, logic [7:0] col,
		logic [7:0] pv, logic [15:0] cf);
		pixel_result_t none;
		none.pix = 8'd0;
		none.st = ST_OK;
		send_command(op, row, col, pv, cf, 1'b0, none);
	endtask

	// Lowers start and waits until every pending result has come back.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_IN_WIDTH: src_w = val[8:0];
			CFG_IN_HEIGHT: src_h = val[8:0];
			CFG_OUT_WIDTH: dst_w = val[8:0];
			CFG_OUT_HEIGHT: dst_h = val[8:0];
			CFG_SCALE: scale_q12 = val;
			CFG_KHALF: taps_half = val[5:0];
			default: ;
		endcase
	endtask

	// Random kernel value: non-positive when asked, else usually positive-weighted, sometimes any 16-bit pattern.
	function automatic logic [15:0] pick_coef(bit non_positive);
		int c;
		if (non_positive)
			c = -int'($urandom_range(32768));
		else if ($urandom_range(7) == 0)
			c = int'($urandom_range(65535)) - 32768;
		else
			c = int'($urandom_range(14000)) - 3000;
		return c[15:0];
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// One phase: set the registers, fill the whole plane and kernel, then random traffic.
	task automatic run_phase(int iw, int ih, int ow, int oh, int sc, int kh, int n,
		bit non_positive);
		int r;
		int c;
		int i;
		int pick;
		drain();
		write_reg(CFG_IN_WIDTH, 16'(iw));
		write_reg(CFG_IN_HEIGHT, 16'(ih));
		write_reg(CFG_OUT_WIDTH, 16'(ow));
		write_reg(CFG_OUT_HEIGHT, 16'(oh));
		write_reg(CFG_SCALE, 16'(sc));
		write_reg(CFG_KHALF, 16'(kh));
		for (r = 0; r < ih; r++)
			for (c = 0; c < iw; c++)
				send_predicted(OP_PIX, 8'(r), 8'(c), pick_byte(), 16'($urandom_range(65535)));
		for (c = 0; c <= DEF_MAX_HALF; c++)
			send_predicted(OP_COEF, 8'($urandom_range(255)), 8'(c), pick_byte(),
				(c == 0 && !non_positive) ? 16'($urandom_range(16384, 6000))
					: pick_coef(non_positive));
		for (i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				if ($urandom_range(9) == 0)
					send_predicted(OP_CMP, 8'($urandom_range(255)), 8'($urandom_range(255)),
						pick_byte(), 16'($urandom_range(65535)));
				else
					send_predicted(OP_CMP, 8'($urandom_range(oh - 1)),
						8'($urandom_range(ow - 1)), pick_byte(), 16'($urandom_range(65535)));
			end else if (pick < 82) begin
				if ($urandom_range(4) == 0)
					send_predicted(OP_PIX, 8'($urandom_range(255)), 8'($urandom_range(255)),
						pick_byte(), 16'($urandom_range(65535)));
				else
					send_predicted(OP_PIX, 8'($urandom_range(ih - 1)),
						8'($urandom_range(iw - 1)), pick_byte(), 16'($urandom_range(65535)));
			end else if (pick < 94) begin
				send_predicted(OP_COEF, 8'($urandom_range(255)), 8'($urandom_range(40)),
					pick_byte(), pick_coef(non_positive));
			end else begin
				send_predicted(2'd3, 8'($urandom_range(255)), 8'($urandom_range(255)),
					pick_byte(), 16'($urandom_range(65535)));
			end
		end
	endtask

	// Directed rows run with the reset register values; all results are known up front.
	directed_row_t directed[] = '{
		'{OP_PIX, 8'd0, 8'd0, 8'd0, 16'h0000, 1'b1, 8'd0, ST_WRITE},
		'{OP_PIX, 8'd255, 8'd255, 8'd255, 16'hFFFF, 1'b1, 8'd0, ST_WRITE},
		'{OP_PIX, 8'd128, 8'd7, 8'hA5, 16'h5A5A, 1'b1, 8'd0, ST_WRITE},
		'{OP_COEF, 8'd0, 8'd0, 8'd0, 16'h8000, 1'b1, 8'd0, ST_WRITE},
		'{OP_COEF, 8'd255, 8'd32, 8'd255, 16'h7FFF, 1'b1, 8'd0, ST_WRITE},
		// Coefficient index beyond the table.
		'{OP_COEF, 8'd0, 8'd33, 8'd0, 16'h4000, 1'b1, 8'd0, ST_ERR},
		'{OP_COEF, 8'd0, 8'd255, 8'd0, 16'h4000, 1'b1, 8'd0, ST_ERR},
		// The fourth opcode is rejected.
		'{2'd3, 8'd0, 8'd0, 8'd0, 16'h0000, 1'b1, 8'd0, ST_ERR},
		'{2'd3, 8'd255, 8'd255, 8'd255, 16'hFFFF, 1'b1, 8'd0, ST_ERR},
		// Compute requests outside the 128 by 128 output.
		'{OP_CMP, 8'd128, 8'd0, 8'd0, 16'h0000, 1'b1, 8'd0, ST_ERR},
		'{OP_CMP, 8'd0, 8'd200, 8'd0, 16'h0000, 1'b1, 8'd0, ST_ERR},
		'{OP_CMP, 8'd255, 8'd255, 8'd0, 16'h0000, 1'b1, 8'd0, ST_ERR}
	};

	initial begin
		pixel_result_t typed;
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_PIX;
		row_index = 8'd0;
		col_index = 8'd0;
		pixel_value = 8'd0;
		coefficient = 16'sd0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_IN_WIDTH;
		cfg_data = '0;
		mismatches = 0;
		results_seen = 0;
		pixels_computed = 0;
		errors_seen = 0;
		src_w = RST_IN_WIDTH;
		src_h = RST_IN_HEIGHT;
		dst_w = RST_OUT_WIDTH;
		dst_h = RST_OUT_HEIGHT;
		scale_q12 = RST_SCALE;
		taps_half = RST_KHALF;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			typed.pix = directed[i].pix;
			typed.st = directed[i].st;
			send_command(directed[i].op, directed[i].row, directed[i].col, directed[i].pv,
				directed[i].cf, directed[i].known, typed);
		end

		// Each phase drains first, so the sender also waits out every pending result.
		run_phase(8, 8, 4, 4, 8192, 2, 60, 1'b0);
		run_phase(6, 5, 6, 5, 4096, 0, 40, 1'b0);
		run_phase(256, 1, 256, 2, 4096, 3, 30, 1'b0);
		run_phase(8, 8, 2, 2, 32768, 63, 6, 1'b0);
		run_phase(6, 6, 6, 6, 5000, 3, 10, 1'b1);

		drain();
		repeat (100) @(posedge clk);
		$display("Checked %0d results: %0d computed pixels, %0d error answers.",
			results_seen, pixels_computed, errors_seen);
		$display("Covered plane sizes 1 to 256, scales 1.0 to 8.0, kernel half widths 0 to 63.");
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20000000;
		$display("Timeout waiting for the block.");
		$display("Test completed with failures");
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/lid_pkg.sv
hw/rtl/lid_ram.sv
hw/rtl/lid_div.sv
hw/rtl/lid_ctrl.sv
hw/rtl/lid_datapath.sv
hw/rtl/lanczos_image_decimator_top.sv
hw/rtl/lid_checker.sv
tb/sv/testbench.sv
